// File: rtl/core/lhrr_pkg.sv
// Shared widths, constants and types for the level history rise-rate unit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lhrr_pkg;

  localparam int DIST_W     = 14;
  localparam int TIME_W     = 32;
  localparam int IVAL_W     = 17;
  localparam int RATE_W     = 25;

  // mag * 960 stays below 2**24 for a 14-bit magnitude.
  localparam int DIVIDEND_W = 24;
  localparam int ELAPSED_W  = 32;
  localparam int STEP_W     = $clog2(DIVIDEND_W);

  // 960 = 2**10 - 2**6, so the scaling is one subtract of two shifts.
  localparam int MUL_SH_HI  = 10;
  localparam int MUL_SH_LO  = 6;

  localparam int                HISTORY_DEPTH_DEF   = 8;
  localparam logic [IVAL_W-1:0] SAMPLE_INTERVAL_RST = IVAL_W'(300);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  typedef struct packed {
    logic              wr;
    logic              clear;
    logic [DIST_W-1:0] distance;
    logic [TIME_W-1:0] stamp;
  } hist_wr_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_stat_t;

endpackage

// File: rtl/core/lhrr_if.sv
// Valid/ready channel interfaces for samples, results and the interval register.
// Depends on lhrr_pkg for the field widths.
`timescale 1ns / 1ps

interface lhrr_in_if;
  import lhrr_pkg::*;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_mm;
  logic [TIME_W-1:0] sample_time_sec;

  modport source (output valid, distance_mm, sample_time_sec, input ready);
  modport sink   (input valid, distance_mm, sample_time_sec, output ready);
endinterface

interface lhrr_out_if;
  import lhrr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] rise_rate_q4;
  logic                     enough_history;
  logic                     used_nominal_timing;

  modport source (output valid, rise_rate_q4, enough_history, used_nominal_timing,
                  input ready);
  modport sink   (input valid, rise_rate_q4, enough_history, used_nominal_timing,
                  output ready);
endinterface

interface lhrr_cfg_if;
  import lhrr_pkg::*;
  logic              valid;
  logic              ready;
  logic [IVAL_W-1:0] interval_sec;

  modport source (output valid, interval_sec, input ready);
  modport sink   (input valid, interval_sec, output ready);
endinterface

// File: rtl/core/level_history_rise_rate_unit.sv
// Top level of the level history rise-rate unit: sequencer, registers, output stage.
// Depends on lhrr_pkg, lhrr_if, lhrr_history and lhrr_div.
`timescale 1ns / 1ps

// Each accepted sample is stored in a ring of the last HISTORY_DEPTH samples
// (emptied first when the interval register differs from the one latched at
// the previous sample) and yields one result: the rise rate from the oldest to
// the newest stored sample in mm per minute with 4 fraction bits, truncated
// toward zero. A sample with at least two stored samples and a nonzero window
// passes through the read, load, divide and done states, the divide state running
// the 24-step serial divider; otherwise the divide state is skipped.
// The next sample is accepted once the result is loaded, even while that
// result still waits in the output register.
module level_history_rise_rate_unit #(
  parameter int HISTORY_DEPTH = lhrr_pkg::HISTORY_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lhrr_in_if.sink    in_chan,
  lhrr_out_if.source out_chan,
  lhrr_cfg_if.sink   cfg_chan
);
  import lhrr_pkg::*;

  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  state_t                state_r, state_nxt;
  logic [IVAL_W-1:0]     cfg_r, latched_r;
  logic [DIST_W-1:0]     d_new_r;
  logic [TIME_W-1:0]     t_new_r;
  logic [ELAPSED_W-1:0]  nom_r;
  logic [CW+IVAL_W-1:0]  nom_prod;
  logic [CW-1:0]         hist_count;
  logic [DIST_W-1:0]     d_old;
  logic [TIME_W-1:0]     t_old;
  hist_wr_t              wr_req;
  div_stat_t             div_stat;
  logic                  in_fire, div_start;
  logic                  use_stamp, falling;
  logic [ELAPSED_W-1:0]  elapsed;
  logic [DIST_W-1:0]     mag;
  logic [DIVIDEND_W-1:0] dividend;
  logic                  falling_r, enough_r, nominal_r;
  logic [DIVIDEND_W-1:0] q_r;
  logic [RATE_W-1:0]     q_ext, rate;
  logic                  load_out;
  logic                  out_valid_r, out_enough_r, out_nom_r;
  logic [RATE_W-1:0]     out_rate_r;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= SAMPLE_INTERVAL_RST;
      latched_r <= '0;
    end else begin
      if (cfg_chan.valid) begin
        cfg_r <= cfg_chan.interval_sec;
      end
      if (in_fire) begin
        latched_r <= cfg_r;
      end
    end
  end

  always_comb begin
    wr_req.wr       = in_fire;
    wr_req.clear    = (latched_r != cfg_r);
    wr_req.distance = in_chan.distance_mm;
    wr_req.stamp    = in_chan.sample_time_sec;
  end

  lhrr_history #(
    .DEPTH (HISTORY_DEPTH),
    .CW    (CW)
  ) u_history (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_req   (wr_req),
    .rd_en    (state_r == ST_READ),
    .count    (hist_count),
    .rd_dist  (d_old),
    .rd_stamp (t_old)
  );

  assign nom_prod = (hist_count - CW'(1)) * latched_r;

  // The newest sample is kept from the input transaction; only the oldest is read back.
  always_comb begin
    use_stamp = (t_old != '0) && (t_new_r > t_old);
    elapsed   = use_stamp ? ELAPSED_W'(t_new_r - t_old) : nom_r;
    falling   = d_new_r > d_old;
    mag       = falling ? d_new_r - d_old : d_old - d_new_r;
    dividend  = (DIVIDEND_W'(mag) << MUL_SH_HI) - (DIVIDEND_W'(mag) << MUL_SH_LO);
  end

  assign div_start = (state_r == ST_LOAD) && (hist_count >= CW'(2)) && (elapsed != '0);

  lhrr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (elapsed),
    .stat     (div_stat)
  );

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = div_start ? ST_DIV : ST_DONE;
      ST_DIV:  if (div_stat.done) state_nxt = ST_DONE;
      ST_DONE: if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      d_new_r <= in_chan.distance_mm;
      t_new_r <= in_chan.sample_time_sec;
    end
    if (state_r == ST_READ) begin
      nom_r <= ELAPSED_W'(nom_prod);
    end
    if (state_r == ST_LOAD) begin
      enough_r  <= (hist_count >= CW'(2));
      nominal_r <= (hist_count >= CW'(2)) && !use_stamp;
      falling_r <= falling;
      q_r       <= '0;
    end else if ((state_r == ST_DIV) && div_stat.done) begin
      q_r <= div_stat.quotient;
    end
  end

  always_comb begin
    q_ext = RATE_W'(q_r);
    rate  = falling_r ? (~q_ext + RATE_W'(1)) : q_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_rate_r   <= rate;
      out_enough_r <= enough_r;
      out_nom_r    <= nominal_r;
    end
  end

  assign out_chan.valid               = out_valid_r;
  assign out_chan.rise_rate_q4        = $signed(out_rate_r);
  assign out_chan.enough_history      = out_enough_r;
  assign out_chan.used_nominal_timing = out_nom_r;

  a_short_history_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && !enough_r) |-> (rate == '0) && !nominal_r)
    else $error("result without enough history is not all zero");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hist_count <= CW'(HISTORY_DEPTH))
    else $error("history count exceeds depth");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_READ))
    else $error("accepted sample did not start a history read");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result shown without passing through the done state");

endmodule

// File: rtl/core/lhrr_history.sv
// Ring buffer of distance/time samples with write pointer and fill count.
// Depends on lhrr_pkg; the oldest entry is read through a registered port.
`timescale 1ns / 1ps

module lhrr_history #(
  parameter int DEPTH = lhrr_pkg::HISTORY_DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lhrr_pkg::hist_wr_t        wr_req,
  input  logic                      rd_en,
  output logic [CW-1:0]             count,
  output logic [lhrr_pkg::DIST_W-1:0] rd_dist,
  output logic [lhrr_pkg::TIME_W-1:0] rd_stamp
);
  import lhrr_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int EW = DIST_W + TIME_W;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data_r;
  logic [PW-1:0] wp_r, wp_nxt, wp_base;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW:0]   old_sum, old_idx;
  logic [PW-1:0] rd_addr;

  always_comb begin
    wp_base = wr_req.clear ? '0 : wp_r;
    wp_nxt  = (wp_base == PW'(DEPTH - 1)) ? '0 : wp_base + PW'(1);
    if (wr_req.clear) begin
      cnt_nxt = CW'(1);
    end else if (cnt_r == CW'(DEPTH)) begin
      cnt_nxt = cnt_r;
    end else begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  // Oldest slot sits count entries behind the write pointer, modulo the depth.
  always_comb begin
    old_sum = (CW + 1)'(wp_r) + (CW + 1)'(DEPTH) - (CW + 1)'(cnt_r);
    old_idx = (old_sum >= (CW + 1)'(DEPTH)) ? old_sum - (CW + 1)'(DEPTH) : old_sum;
    rd_addr = old_idx[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      cnt_r <= '0;
    end else if (wr_req.wr) begin
      wp_r  <= wp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_req.wr) begin
      mem[wp_base] <= {wr_req.distance, wr_req.stamp};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign count    = cnt_r;
  assign rd_dist  = rd_data_r[EW-1:TIME_W];
  assign rd_stamp = rd_data_r[TIME_W-1:0];

endmodule

// File: rtl/core/lhrr_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on lhrr_pkg for operand widths and the status struct.
`timescale 1ns / 1ps

module lhrr_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [lhrr_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [lhrr_pkg::ELAPSED_W-1:0]  divisor,
  output lhrr_pkg::div_stat_t             stat
);
  import lhrr_pkg::*;

  logic                  busy_r, done_r;
  logic [STEP_W-1:0]     step_r;
  logic [ELAPSED_W-1:0]  rem_r, rem_nxt, dvs_r;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [ELAPSED_W:0]    trial, diff;
  logic                  ge;

  // quo_r shifts dividend bits out at the top and quotient bits in at the bottom.
  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[ELAPSED_W-1:0] : trial[ELAPSED_W-1:0];
    quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DIVIDEND_W - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          step_r <= step_r - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.done     = done_r;
  assign stat.quotient = quo_r;

endmodule
